FILE: sv/wsfp_pkg.sv
`default_nettype none
package wsfp_pkg;

  typedef enum logic [2:0] {
    PH_HDR1  = 3'd0,
    PH_HDR2  = 3'd1,
    PH_EXT16 = 3'd2,
    PH_EXT64 = 3'd3,
    PH_KEY   = 3'd4,
    PH_DATA  = 3'd5
  } phase_e;

  localparam logic [6:0] Len16Code = 7'd126;
  localparam logic [6:0] Len64Code = 7'd127;
  localparam logic [2:0] Ext16Last = 3'd1;
  localparam logic [2:0] Ext64Last = 3'd7;
  localparam logic [1:0] KeyLast   = 2'd3;

  typedef struct packed {
    logic [7:0]  data;
    logic        empty;
    logic        fin;
    logic [3:0]  opcode;
    logic        masked;
    logic [63:0] length;
    logic        first;
    logic        last;
  } res_t;

endpackage
`default_nettype wire

FILE: sv/wsfp_in_if.sv
`default_nettype none
interface wsfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface
`default_nettype wire

FILE: sv/wsfp_out_if.sv
`default_nettype none
interface wsfp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        empty_frame;
  logic        fin_flag;
  logic [3:0]  frame_opcode;
  logic        was_masked;
  logic [63:0] frame_length;
  logic        first_of_frame;
  logic        last_of_frame;

  modport source (
    output valid, output out_byte, output empty_frame, output fin_flag,
    output frame_opcode, output was_masked, output frame_length,
    output first_of_frame, output last_of_frame, input ready
  );
  modport sink (
    input valid, input out_byte, input empty_frame, input fin_flag,
    input frame_opcode, input was_masked, input frame_length,
    input first_of_frame, input last_of_frame, output ready
  );
endinterface
`default_nettype wire

FILE: sv/websocket_frame_parser.sv
// websocket frame parser: streaming deframer for received websocket bytes
// in_i  : one received byte per request (valid/ready)
// out_o : one result per payload byte, unmasked, tagged with fin, opcode,
//         mask flag, decoded length and first/last marks; a frame of zero
//         length gives a single empty-frame marker once its header is done
// header bytes (both base bytes, extended length, masking key) give no result
// throughput: one byte per cycle, sustained, while out_o keeps taking results
// output: a result is registered into the output register, or into the skid
//   register while out_o holds an unaccepted result; the byte is decoded by
//   one level of logic between the frame state registers and the output register
// stall: a two-entry output buffer (output register plus skid register) lets
//   one more byte in while a result waits; in_i.ready drops only when both
//   entries hold a result
// reset: rst_ni low clears the parser to expect the first header byte and
//   empties the output buffer
`default_nettype none
module websocket_frame_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  wsfp_in_if.sink           in_i,
  wsfp_out_if.source        out_o
);

  wsfp_pkg::phase_e phase_q, phase_d;
  logic             fin_q, fin_d;
  logic [3:0]       op_q, op_d;
  logic             mask_q, mask_d;
  logic [63:0]      len_q, len_d;
  logic [2:0]       cnt_q, cnt_d;
  logic [31:0]      key_q, key_d;
  logic [63:0]      remain_q, remain_d;
  logic [1:0]       idx_q, idx_d;
  logic             first_q, first_d;

  logic             enter;
  logic             produce;
  logic             len_zero;
  logic [7:0]       b;
  logic [6:0]       len7;
  logic [2:0]       need;
  wsfp_pkg::res_t   res;

  logic             fire;
  logic             pop;
  logic             out_valid_q;
  logic             skid_valid_q;
  wsfp_pkg::res_t   out_q;
  wsfp_pkg::res_t   skid_q;

  assign b        = in_i.in_byte;
  assign len7     = b[6:0];
  assign need     = (phase_q == wsfp_pkg::PH_EXT16) ? wsfp_pkg::Ext16Last
                                                    : wsfp_pkg::Ext64Last;
  assign len_zero = (len_d == 64'd0);

  assign in_i.ready = !skid_valid_q;
  assign fire       = in_i.valid && in_i.ready;
  assign pop        = out_valid_q && out_o.ready;

  // frame datapath and result for the byte on in_i
  always_comb begin
    fin_d    = fin_q;
    op_d     = op_q;
    mask_d   = mask_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    key_d    = key_q;
    remain_d = remain_q;
    idx_d    = idx_q;
    first_d  = first_q;
    enter    = 1'b0;
    produce  = 1'b0;
    res      = '0;
    case (phase_q)
      wsfp_pkg::PH_HDR2: begin
        mask_d = b[7];
        cnt_d  = 3'd0;
        if (len7 == wsfp_pkg::Len16Code || len7 == wsfp_pkg::Len64Code) begin
          len_d = 64'd0;
        end else begin
          len_d = {57'd0, len7};
          if (b[7]) begin
            key_d = 32'd0;
          end else begin
            enter = 1'b1;
          end
        end
      end
      wsfp_pkg::PH_EXT16, wsfp_pkg::PH_EXT64: begin
        len_d = {len_q[55:0], b};
        if (cnt_q >= need) begin
          cnt_d = 3'd0;
          if (mask_q) begin
            key_d = 32'd0;
          end else begin
            enter = 1'b1;
          end
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      wsfp_pkg::PH_KEY: begin
        key_d[{cnt_q[1:0], 3'b000} +: 8] = key_q[{cnt_q[1:0], 3'b000} +: 8] | b;
        if (cnt_q[1:0] == wsfp_pkg::KeyLast) begin
          enter = 1'b1;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      wsfp_pkg::PH_DATA: begin
        produce    = 1'b1;
        res.data   = mask_q ? (b ^ key_q[{idx_q, 3'b000} +: 8]) : b;
        res.first  = first_q;
        res.last   = (remain_q == 64'd1);
        remain_d   = remain_q - 64'd1;
        idx_d      = idx_q + 2'd1;
        first_d    = 1'b0;
      end
      default: begin
        fin_d = b[7];
        op_d  = b[3:0];
      end
    endcase
    // header complete: arm the payload counters, and emit the empty marker for a zero-length frame
    if (enter) begin
      cnt_d    = 3'd0;
      first_d  = 1'b1;
      idx_d    = 2'd0;
      remain_d = len_d;
      if (len_zero) begin
        produce   = 1'b1;
        res.data  = 8'd0;
        res.empty = 1'b1;
        res.first = 1'b1;
        res.last  = 1'b1;
      end
    end
    res.fin    = fin_d;
    res.opcode = op_d;
    res.masked = mask_d;
    res.length = len_d;
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (enter) begin
      phase_d = len_zero ? wsfp_pkg::PH_HDR1 : wsfp_pkg::PH_DATA;
    end else begin
      case (phase_q)
        wsfp_pkg::PH_HDR2: begin
          if (len7 == wsfp_pkg::Len16Code) begin
            phase_d = wsfp_pkg::PH_EXT16;
          end else if (len7 == wsfp_pkg::Len64Code) begin
            phase_d = wsfp_pkg::PH_EXT64;
          end else begin
            phase_d = wsfp_pkg::PH_KEY;
          end
        end
        wsfp_pkg::PH_EXT16, wsfp_pkg::PH_EXT64: begin
          if (cnt_q >= need) begin
            phase_d = wsfp_pkg::PH_KEY;
          end
        end
        wsfp_pkg::PH_KEY: phase_d = wsfp_pkg::PH_KEY;
        wsfp_pkg::PH_DATA: begin
          if (remain_q == 64'd1) begin
            phase_d = wsfp_pkg::PH_HDR1;
          end
        end
        default: phase_d = wsfp_pkg::PH_HDR2;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= wsfp_pkg::PH_HDR1;
      cnt_q   <= 3'd0;
    end else if (fire) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      fin_q    <= fin_d;
      op_q     <= op_d;
      mask_q   <= mask_d;
      len_q    <= len_d;
      key_q    <= key_d;
      remain_q <= remain_d;
      idx_q    <= idx_d;
      first_q  <= first_d;
    end
  end

  // two-entry output buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (fire && produce) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (fire && produce) begin
      if (out_valid_q && !pop) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.out_byte       = out_q.data;
  assign out_o.empty_frame    = out_q.empty;
  assign out_o.fin_flag       = out_q.fin;
  assign out_o.frame_opcode   = out_q.opcode;
  assign out_o.was_masked     = out_q.masked;
  assign out_o.frame_length   = out_q.length;
  assign out_o.first_of_frame = out_q.first;
  assign out_o.last_of_frame  = out_q.last;

endmodule
`default_nettype wire

FILE: sv/wsfp_checker.sv
`default_nettype none
module wsfp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       empty_frame_i,
  input logic       first_of_frame_i,
  input logic       last_of_frame_i
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // empty marker is a whole frame of its own with a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && empty_frame_i |->
      out_byte_i == 8'd0 && first_of_frame_i && last_of_frame_i)
    else $error("malformed empty-frame marker");

  // a new result only follows a taken byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i))
    else $error("result without request");

  // input backpressure only while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with empty output");

endmodule

bind websocket_frame_parser wsfp_checker u_wsfp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_byte_i       (out_o.out_byte),
  .empty_frame_i    (out_o.empty_frame),
  .first_of_frame_i (out_o.first_of_frame),
  .last_of_frame_i  (out_o.last_of_frame)
);
`default_nettype wire
